// ===== sv/lps_pkg.sv =====
package lps_pkg;

  localparam int COORD_BITS = 9;
  localparam int COLOR_BITS = 16;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int REM_BITS   = COORD_BITS + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [REM_BITS-1:0]   rem_t;
  typedef logic [FIFO_CW-1:0]    fifo_cnt_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd3
  } dir_t;

  typedef struct packed {
    op_t    op;
    coord_t x_start;
    coord_t y_start;
    coord_t abs_dx;
    coord_t abs_dy;
    dir_t   dir_x;
    dir_t   dir_y;
    coord_t major;
    color_t color;
  } cmd_t;

  typedef struct packed {
    logic active;
    rem_t remaining;
  } back_stat_t;

endpackage

// ===== sv/lps_if.sv =====
interface lps_in_if;
  import lps_pkg::*;
  logic   valid;
  logic   ready;
  logic   op;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;
  color_t color;

  modport source (output valid, output op, output x_start, output y_start,
                  output x_end, output y_end, output color, input ready);
  modport sink   (input valid, input op, input x_start, input y_start,
                  input x_end, input y_end, input color, output ready);
endinterface

interface lps_out_if;
  import lps_pkg::*;
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  output last, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                  input last, output ready);
endinterface

// ===== sv/lps_front.sv =====
module lps_front (
  lps_in_if.sink         in_ch,
  output logic           push_valid,
  input  logic           push_ready,
  output lps_pkg::cmd_t  push_cmd
);
  import lps_pkg::*;

  coord_t abs_dx;
  coord_t abs_dy;
  dir_t   dir_x;
  dir_t   dir_y;

  always_comb begin
    if (in_ch.x_end > in_ch.x_start) begin
      abs_dx = in_ch.x_end - in_ch.x_start;
      dir_x  = DIR_UP;
    end else if (in_ch.x_end < in_ch.x_start) begin
      abs_dx = in_ch.x_start - in_ch.x_end;
      dir_x  = DIR_DOWN;
    end else begin
      abs_dx = '0;
      dir_x  = DIR_NONE;
    end
    if (in_ch.y_end > in_ch.y_start) begin
      abs_dy = in_ch.y_end - in_ch.y_start;
      dir_y  = DIR_UP;
    end else if (in_ch.y_end < in_ch.y_start) begin
      abs_dy = in_ch.y_start - in_ch.y_end;
      dir_y  = DIR_DOWN;
    end else begin
      abs_dy = '0;
      dir_y  = DIR_NONE;
    end
  end

  always_comb begin
    push_cmd.op      = op_t'(in_ch.op);
    push_cmd.x_start = in_ch.x_start;
    push_cmd.y_start = in_ch.y_start;
    push_cmd.abs_dx  = abs_dx;
    push_cmd.abs_dy  = abs_dy;
    push_cmd.dir_x   = dir_x;
    push_cmd.dir_y   = dir_y;
    push_cmd.major   = (abs_dx > abs_dy) ? abs_dx : abs_dy;
    push_cmd.color   = in_ch.color;
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

// ===== sv/lps_fifo.sv =====
module lps_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  lps_pkg::cmd_t       push_cmd,
  output logic                pop_valid,
  input  logic                pop_ready,
  output lps_pkg::cmd_t       pop_cmd,
  output lps_pkg::fifo_cnt_t  count
);
  import lps_pkg::*;

  cmd_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  fifo_cnt_t           count_r, count_nxt;
  logic                push, pop;

  assign push_ready = (count_r != fifo_cnt_t'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign count      = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/lps_back.sv =====
module lps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  lps_pkg::cmd_t        pop_cmd,
  lps_out_if.source            out_ch,
  output lps_pkg::back_stat_t  stat
);
  import lps_pkg::*;

  logic   active_r, active_nxt;
  rem_t   remaining_r, remaining_nxt;
  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  err_t   err_x_r, err_x_nxt;
  err_t   err_y_r, err_y_nxt;
  coord_t abs_dx_r, abs_dx_nxt;
  coord_t abs_dy_r, abs_dy_nxt;
  dir_t   dir_x_r, dir_x_nxt;
  dir_t   dir_y_r, dir_y_nxt;
  coord_t major_r, major_nxt;
  color_t color_r, color_nxt;

  logic   out_valid_r, out_valid_nxt;
  coord_t out_x_r, out_x_nxt;
  coord_t out_y_r, out_y_nxt;
  color_t out_color_r, out_color_nxt;
  logic   out_last_r, out_last_nxt;

  logic   is_start, out_free, do_start, do_step;
  err_t   sum_x, sum_y, major_ext;

  function automatic coord_t move_coord(coord_t c, dir_t d);
    coord_t r;
    case (d)
      DIR_UP:   r = c + 1'b1;
      DIR_DOWN: r = c - 1'b1;
      default:  r = c;
    endcase
    return r;
  endfunction

  assign is_start  = (pop_cmd.op == OP_START);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign pop_ready = is_start || !active_r || out_free;
  assign do_start  = pop_valid && is_start;
  assign do_step   = pop_valid && !is_start && active_r && out_free;
  assign sum_x     = err_x_r + err_t'(abs_dx_r);
  assign sum_y     = err_y_r + err_t'(abs_dy_r);
  assign major_ext = err_t'(major_r);

  always_comb begin
    active_nxt    = active_r;
    remaining_nxt = remaining_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_x_nxt     = err_x_r;
    err_y_nxt     = err_y_r;
    abs_dx_nxt    = abs_dx_r;
    abs_dy_nxt    = abs_dy_r;
    dir_x_nxt     = dir_x_r;
    dir_y_nxt     = dir_y_r;
    major_nxt     = major_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;

    if (do_start) begin
      active_nxt    = 1'b1;
      remaining_nxt = rem_t'(pop_cmd.major) + rem_t'(2);
      cur_x_nxt     = pop_cmd.x_start;
      cur_y_nxt     = pop_cmd.y_start;
      err_x_nxt     = '0;
      err_y_nxt     = '0;
      abs_dx_nxt    = pop_cmd.abs_dx;
      abs_dy_nxt    = pop_cmd.abs_dy;
      dir_x_nxt     = pop_cmd.dir_x;
      dir_y_nxt     = pop_cmd.dir_y;
      major_nxt     = pop_cmd.major;
      color_nxt     = pop_cmd.color;
    end else if (do_step) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = cur_x_r;
      out_y_nxt     = cur_y_r;
      out_color_nxt = color_r;
      out_last_nxt  = (remaining_r == rem_t'(1));
      remaining_nxt = remaining_r - 1'b1;
      active_nxt    = (remaining_r != rem_t'(1));
      err_x_nxt     = sum_x;
      err_y_nxt     = sum_y;
      if (sum_x > major_ext) begin
        err_x_nxt = sum_x - major_ext;
        cur_x_nxt = move_coord(cur_x_r, dir_x_r);
      end
      if (sum_y > major_ext) begin
        err_y_nxt = sum_y - major_ext;
        cur_y_nxt = move_coord(cur_y_r, dir_y_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      remaining_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      remaining_r <= remaining_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    err_x_r     <= err_x_nxt;
    err_y_r     <= err_y_nxt;
    abs_dx_r    <= abs_dx_nxt;
    abs_dy_r    <= abs_dy_nxt;
    dir_x_r     <= dir_x_nxt;
    dir_y_r     <= dir_y_nxt;
    major_r     <= major_nxt;
    color_r     <= color_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.last        = out_last_r;

  assign stat.active    = active_r;
  assign stat.remaining = remaining_r;

endmodule

// ===== sv/line_pixel_stepper.sv =====
// channel  | dir | handshake          | payload
// in_ch    | in  | valid/ready        | op, x_start, y_start, x_end, y_end, color
// out_ch   | out | valid/ready        | pixel_x, pixel_y, pixel_color, last
//
// One item per cycle unless the output stalls; a step item's pixel appears
// in the cycle after it leaves the four-entry command queue, through a
// single output register. A start item loads the stepper and gives no pixel.
// rst_n (synchronous) empties the queue, drops any line and the output item.
// A stalled output holds step items of an active line; the queue keeps taking items until full.
module line_pixel_stepper (
  input  logic      clk,
  input  logic      rst_n,
  lps_in_if.sink    in_ch,
  lps_out_if.source out_ch
);
  import lps_pkg::*;

  logic       push_valid, push_ready;
  cmd_t       push_cmd;
  logic       pop_valid, pop_ready;
  cmd_t       pop_cmd;
  fifo_cnt_t  fifo_count;
  back_stat_t back_stat;

  lps_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lps_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .count      (fifo_count)
  );

  lps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_ch    (out_ch),
    .stat      (back_stat)
  );

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count <= fifo_cnt_t'(FIFO_DEPTH))
    else $error("command queue over depth");

  a_fifo_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && $past(rst_n) |-> (fifo_count == $past(fifo_count) ||
      fifo_count == $past(fifo_count) + 1'b1 || fifo_count + 1'b1 == $past(fifo_count)))
    else $error("command queue count jumped");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !back_stat.active |-> back_stat.remaining == '0)
    else $error("idle stepper with pixels left");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
  import lps_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEM_TARGET  = 1925;

  typedef struct {
    op_t    op;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t color;
  } seg_req_t;

  typedef struct {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  lps_in_if  in_ch ();
  lps_out_if out_ch ();

  line_pixel_stepper u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seg_req_t pending_q[$];
  pixel_t   pixel_q[$];
  int       mismatches = 0;
  int       cycle_cnt = 0;

  // line state mirrored from the stepper
  logic   ln_active = 1'b0;
  coord_t ln_x = '0;
  coord_t ln_y = '0;
  err_t   ln_err_x = '0;
  err_t   ln_err_y = '0;
  coord_t ln_abs_dx = '0;
  coord_t ln_abs_dy = '0;
  dir_t   ln_dir_x = DIR_NONE;
  dir_t   ln_dir_y = DIR_NONE;
  coord_t ln_major = '0;
  rem_t   ln_left = '0;
  color_t ln_color = '0;

  function automatic void setup_axis(input coord_t a, input coord_t b,
                                     output coord_t delta, output dir_t dir);
    if (b > a) begin
      delta = b - a;
      dir   = DIR_UP;
    end else if (b < a) begin
      delta = a - b;
      dir   = DIR_DOWN;
    end else begin
      delta = '0;
      dir   = DIR_NONE;
    end
  endfunction

  function automatic coord_t move_coord(input coord_t c, input dir_t dir);
    case (dir)
      DIR_UP:   return c + coord_t'(1);
      DIR_DOWN: return c - coord_t'(1);
      default:  return c;
    endcase
  endfunction

  task automatic predict_pixel(input seg_req_t req);
    pixel_t px;
    if (req.op == OP_START) begin
      setup_axis(req.x_start, req.x_end, ln_abs_dx, ln_dir_x);
      setup_axis(req.y_start, req.y_end, ln_abs_dy, ln_dir_y);
      ln_major  = (ln_abs_dx > ln_abs_dy) ? ln_abs_dx : ln_abs_dy;
      ln_x      = req.x_start;
      ln_y      = req.y_start;
      ln_err_x  = '0;
      ln_err_y  = '0;
      ln_left   = rem_t'(ln_major) + rem_t'(2);
      ln_color  = req.color;
      ln_active = 1'b1;
    end else if (ln_active) begin
      px.x     = ln_x;
      px.y     = ln_y;
      px.color = ln_color;
      ln_err_x = ln_err_x + err_t'(ln_abs_dx);
      ln_err_y = ln_err_y + err_t'(ln_abs_dy);
      if (ln_err_x > err_t'(ln_major)) begin
        ln_err_x = ln_err_x - err_t'(ln_major);
        ln_x     = move_coord(ln_x, ln_dir_x);
      end
      if (ln_err_y > err_t'(ln_major)) begin
        ln_err_y = ln_err_y - err_t'(ln_major);
        ln_y     = move_coord(ln_y, ln_dir_y);
      end
      ln_left = ln_left - rem_t'(1);
      px.last = (ln_left == '0);
      if (px.last) ln_active = 1'b0;
      pixel_q.push_back(px);
    end
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_start(input coord_t xs, input coord_t ys, input coord_t xe,
                            input coord_t ye, input color_t c);
    seg_req_t req;
    req.op      = OP_START;
    req.x_start = xs;
    req.y_start = ys;
    req.x_end   = xe;
    req.y_end   = ye;
    req.color   = c;
    pending_q.push_back(req);
  endtask

  task automatic push_steps(input int n);
    seg_req_t req;
    for (int i = 0; i < n; i++) begin
      req.op      = OP_STEP;
      req.x_start = coord_t'($urandom);
      req.y_start = coord_t'($urandom);
      req.x_end   = coord_t'($urandom);
      req.y_end   = coord_t'($urandom);
      req.color   = color_t'($urandom);
      pending_q.push_back(req);
    end
  endtask

  function automatic coord_t near_coord(input coord_t base, input int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 511) v = 511;
    return coord_t'(v);
  endfunction

  function automatic coord_t pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return coord_t'($urandom);
  endfunction

  // input driver
  seg_req_t in_item;
  logic     in_busy = 1'b0;
  logic     in_calm = 1'b0;
  int       in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_busy = 1'b0;
      in_gap  = 0;
    end else begin
      if (in_busy && in_ch.ready) begin
        predict_pixel(in_item);
        in_busy = 1'b0;
        in_gap  = in_calm ? 0 : draw_gap();
        if ($urandom_range(0, 149) == 0) in_calm = !in_calm;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_q.size() > 0) begin
          in_item          = pending_q.pop_front();
          in_busy          = 1'b1;
          in_ch.op        <= in_item.op;
          in_ch.x_start   <= in_item.x_start;
          in_ch.y_start   <= in_item.y_start;
          in_ch.x_end     <= in_item.x_end;
          in_ch.y_end     <= in_item.y_end;
          in_ch.color     <= in_item.color;
        end
      end
    end
    in_ch.valid <= in_busy;
  end

  // result monitor
  logic out_calm = 1'b0;
  int   out_stall = 0;

  always @(posedge clk) begin
    pixel_t want;
    logic   rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel x=%0d y=%0d color=%h last=%b",
                     out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color, out_ch.last);
        end else begin
          want = pixel_q.pop_front();
          if (out_ch.pixel_x !== want.x || out_ch.pixel_y !== want.y ||
              out_ch.pixel_color !== want.color || out_ch.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("expected x=%0d y=%0d c=%h l=%b, got x=%0d y=%0d c=%h l=%b",
                       want.x, want.y, want.color, want.last,
                       out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color, out_ch.last);
          end
        end
      end
      if ($urandom_range(0, 399) == 0) out_calm = !out_calm;
      if (out_stall > 0) begin
        out_stall--;
      end else begin
        rdy = 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0) out_stall = draw_gap();
      end
    end
    out_ch.ready <= rdy;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int     r;
    int     nsteps;
    int     major_len;
    int     span;
    coord_t xs, ys, xe, ye;

    rst_n = 1'b0;

    // step while idle, extreme diagonals cut short by a new start
    push_steps(1);
    push_start('0, '0, '1, '1, '1);
    push_steps(3);
    push_start('1, '1, '0, '0, '0);
    push_steps(3);
    push_start('1, '0, '0, '1, 16'h5555);
    push_steps(3);
    // zero-length line, then one extra step after the end
    push_start(9'd5, 9'd5, 9'd5, 9'd5, 16'haaaa);
    push_steps(3);
    push_start(9'd0, 9'd7, 9'd3, 9'd7, 16'h1234);
    push_steps(5);
    push_start(9'd9, 9'd2, 9'd9, 9'd0, 16'hfedc);
    push_steps(4);

    while (pending_q.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        xs = pick_coord();
        ys = pick_coord();
        if ($urandom_range(0, 49) == 0) begin
          xe = pick_coord();
          ye = pick_coord();
        end else begin
          span = ($urandom_range(0, 4) == 0) ? 60 : 12;
          xe = near_coord(xs, span);
          ye = near_coord(ys, span);
        end
        push_start(xs, ys, xe, ye, color_t'($urandom));
        major_len = (xe > xs) ? xe - xs : xs - xe;
        if (((ye > ys) ? ye - ys : ys - ye) > major_len)
          major_len = (ye > ys) ? ye - ys : ys - ye;
        nsteps = major_len + 2;
        if (r >= 80) nsteps = $urandom_range(0, nsteps - 1);
        else if ($urandom_range(0, 4) == 0) nsteps += $urandom_range(1, 2);
        push_steps(nsteps);
      end else begin
        for (int i = 0; i < $urandom_range(1, 5); i++) begin
          if ($urandom_range(0, 1) == 0) push_steps(1);
          else push_start(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), color_t'($urandom));
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() > 0 || in_busy) @(posedge clk);
    while (pixel_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pixel_q.size() > 0) begin
      mismatches += pixel_q.size();
      $display("%0d expected pixels never arrived", pixel_q.size());
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
